// ----- rtl/svp_pkg.sv -----
// Shared types, constants and controller/datapath interface structs for the
// sliding-window percentile statistics block. No dependencies.
package svp_pkg;

  localparam int HIST_DEPTH_DEF = 256;
  localparam int SAMPLE_W       = 24;
  localparam int PCT_W          = 14;
  localparam int COUNT_OUT_W    = 9;
  localparam int OP_W           = 2;
  // Mean divider widths: the dividend covers the window sum and the
  // divisor covers the fill count.
  localparam int DIVD_W         = 40;
  localparam int DVS_W          = 14;

  localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
    logic [PCT_W-1:0]    percent_x100;
  } svp_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]    average;
    logic [SAMPLE_W-1:0]    percentile_value;
    logic [SAMPLE_W-1:0]    last_sample;
    logic [COUNT_OUT_W-1:0] sample_count;
  } svp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QCHK,
    ST_RWAIT,
    ST_ORD,
    ST_OLAT,
    ST_INNER,
    ST_OEVAL,
    ST_MGO,
    ST_MWAIT,
    ST_FMUL,
    ST_FGO,
    ST_FWAIT,
    ST_FLO,
    ST_DONE
  } svp_state_t;

  typedef struct packed {
    logic      push;
    logic      clear;
    logic      q_init;
    logic      div_start;
    logic      rank_div;
    logic      cap_rank;
    logic      cap_mean;
    logic      frac_hi;
    logic      frac_rem;
    logic      cap_frac;
    logic      outer_rd;
    logic      outer_lat;
    logic      inner_step;
    logic      outer_eval;
    logic      frac_mul;
    logic      load_out;
  } svp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic inner_done;
    logic outer_last;
    logic div_done;
  } svp_sts_t;

endpackage

// ----- rtl/sliding_window_percentile_stats.sv -----
// Top level of the sliding-window percentile statistics block.
// Depends on svp_pkg, svp_ctrl and svp_datapath.
//
// Keeps the last HISTORY_DEPTH samples in a single-port-read RAM. In a
// query, every window entry is read once as a candidate and then compared
// against the whole window through the one RAM read port to find its rank,
// the mean takes a pass through a bit-serial divider, and the rank and
// interpolation divisions by 10000 use reciprocal multiplication. An empty
// window goes straight to the result. A finished result sits in an output
// register, so a new item is taken while it waits; a further query stalls
// at its end until that register is free.
module sliding_window_percentile_stats #(
  parameter int HISTORY_DEPTH = svp_pkg::HIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  svp_pkg::svp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output svp_pkg::svp_out_t out_data
);

  svp_pkg::svp_cmd_t cmd;
  svp_pkg::svp_sts_t sts;

  svp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  svp_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- rtl/svp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/svp_div.sv -----
// Restoring divider, one quotient bit per cycle, used for the window mean.
// Depends on svp_pkg.
module svp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [svp_pkg::DIVD_W-1:0] dividend,
  input  logic [svp_pkg::DVS_W-1:0]  divisor,
  output logic [svp_pkg::DIVD_W-1:0] quo,
  output logic                       done
);

  localparam int CNT_W = $clog2(svp_pkg::DIVD_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(svp_pkg::DIVD_W);

  logic [svp_pkg::DIVD_W-1:0] quo_r;
  logic [svp_pkg::DVS_W-1:0]  rem_r, den_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       done_r;
  logic [svp_pkg::DVS_W:0]    sh, dif;
  logic                       ge;

  always_comb begin
    sh  = {rem_r, quo_r[svp_pkg::DIVD_W-1]};
    dif = sh - {1'b0, den_r};
    ge  = (sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= STEPS;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[svp_pkg::DIVD_W-2:0], ge};
      rem_r <= ge ? dif[svp_pkg::DVS_W-1:0] : sh[svp_pkg::DVS_W-1:0];
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- rtl/svp_datapath.sv -----
// Datapath: history ring, head/count state, rank counting, accumulators,
// mean divider, divisions by 10000 and the output register.
// Depends on svp_pkg, svp_ram, svp_div.
module svp_datapath #(
  parameter int HISTORY_DEPTH = svp_pkg::HIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  svp_pkg::svp_in_t  in_data,
  input  svp_pkg::svp_cmd_t cmd,
  output svp_pkg::svp_sts_t sts,
  output svp_pkg::svp_out_t out_data
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int SW     = svp_pkg::SAMPLE_W;
  localparam int SUM_W  = SW + CW;
  localparam int RANK_W = svp_pkg::PCT_W + CW;
  localparam int PROD_W = SW + svp_pkg::PCT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(HISTORY_DEPTH - 1);
  // A division by 10000 is a 4-bit shift followed by a division by 625.
  // The reciprocal multiplication below is exact for dividends under 2**27.
  localparam int QW   = 27;
  localparam int DQ_W = 18;
  localparam int P_W  = 2 * QW + 1;
  localparam int FL_W = 17;
  localparam int FY_W = PROD_W - 4;
  localparam logic [QW:0]   RECIP_625 = 28'd219902326;
  localparam logic [QW-1:0] K625      = 27'd625;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_A) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [DQ_W-1:0] div625(input logic [QW-1:0] x);
    logic [P_W-1:0] p;
    p = P_W'(x) * P_W'(RECIP_625);
    return p[P_W-1:P_W-DQ_W];
  endfunction

  logic [AW-1:0]     head_r, optr_r, iptr_r, oldest, raddr;
  logic [CW-1:0]     count_r, ocnt_r, icnt_r, lt_r, eq_r, lo_r, hi_r, lo_w, cnt_m1;
  logic [SW-1:0]     last_r, v_r, a_r, b_r, avg_r, pv_r, rdata;
  logic [SUM_W-1:0]  sum_r;
  logic [RANK_W-1:0] rank_r;
  logic [PROD_W-1:0] prod_r;
  logic [svp_pkg::PCT_W-1:0] frem_r, pct_sat;
  logic [CW:0]       head_e, old_e, lt_eq;
  logic [svp_pkg::DIVD_W-1:0] div_dvd, quo;
  logic [svp_pkg::DVS_W-1:0]  div_dvs;
  logic              div_done, lo_hit, hi_hit;
  logic [CW+svp_pkg::COUNT_OUT_W-1:0] cnt_ext;
  logic [FY_W-1:0]       fy;
  logic [FY_W-FL_W-1:0]  fh;
  logic [QW-1:0]         d_in, fz_r;
  logic [DQ_W-1:0]       d_q, lo_q_r, fq_r;
  logic [DQ_W+FL_W-1:0]  fq_all;
  svp_pkg::svp_out_t out_r;

  svp_ram #(.WIDTH(SW), .DEPTH(HISTORY_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (head_r),
    .wdata (in_data.sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  svp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo      (quo),
    .done     (div_done)
  );

  always_comb begin
    head_e = {{(CW + 1 - AW){1'b0}}, head_r};
    if (head_e >= {1'b0, count_r}) begin
      old_e = head_e - {1'b0, count_r};
    end else begin
      old_e = head_e + {1'b0, DEPTH_C} - {1'b0, count_r};
    end
    oldest = old_e[AW-1:0];

    if (cmd.outer_lat) begin
      raddr = oldest;
    end else if (cmd.inner_step) begin
      raddr = iptr_r;
    end else begin
      raddr = optr_r;
    end

    pct_sat = (in_data.percent_x100 > svp_pkg::PCT_FULL) ? svp_pkg::PCT_FULL
                                                         : in_data.percent_x100;
    cnt_m1  = count_r - CW'(1);
    lo_w    = lo_q_r[CW-1:0];

    // A candidate occupies ranks lt .. lt+eq-1 in the sorted window.
    lt_eq  = {1'b0, lt_r} + {1'b0, eq_r};
    lo_hit = (lo_r >= lt_r) && ({1'b0, lo_r} < lt_eq);
    hi_hit = (hi_r >= lt_r) && ({1'b0, hi_r} < lt_eq);

    div_dvd = svp_pkg::DIVD_W'(sum_r);
    div_dvs = svp_pkg::DVS_W'(count_r);

    // The interpolation product, shifted down by 4 bits, is split at bit 17 so
    // that each of its two divisions by 625 stays within the exact range of the reciprocal.
    fy = prod_r[PROD_W-1:4];
    fh = fy[FY_W-1:FL_W];
    if (cmd.rank_div) begin
      d_in = QW'(rank_r[RANK_W-1:4]);
    end else if (cmd.frac_hi) begin
      d_in = QW'(fh);
    end else begin
      d_in = fz_r;
    end
    d_q    = div625(d_in);
    fq_all = {fq_r, d_q[FL_W-1:0]};

    cnt_ext = {{svp_pkg::COUNT_OUT_W{1'b0}}, count_r};

    sts.cnt_zero   = (count_r == '0);
    sts.inner_done = (icnt_r == count_r);
    sts.outer_last = (ocnt_r == cnt_m1);
    sts.div_done   = div_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      last_r  <= '0;
    end else if (cmd.push) begin
      head_r  <= wrap_inc(head_r);
      if (count_r != DEPTH_C) begin
        count_r <= count_r + CW'(1);
      end
      last_r  <= in_data.sample;
    end else if (cmd.clear) begin
      head_r  <= '0;
      count_r <= '0;
      last_r  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      sum_r  <= '0;
      ocnt_r <= '0;
      optr_r <= oldest;
      avg_r  <= '0;
      pv_r   <= '0;
      rank_r <= RANK_W'(pct_sat) * RANK_W'(cnt_m1);
    end
    if (cmd.rank_div) begin
      lo_q_r <= d_q;
    end
    if (cmd.cap_rank) begin
      lo_r   <= lo_w;
      hi_r   <= (lo_w == cnt_m1) ? lo_w : lo_w + CW'(1);
      frem_r <= svp_pkg::PCT_W'(rank_r - RANK_W'(lo_w) * RANK_W'(svp_pkg::PCT_FULL));
    end
    if (cmd.outer_lat) begin
      v_r    <= rdata;
      sum_r  <= sum_r + SUM_W'(rdata);
      lt_r   <= '0;
      eq_r   <= '0;
      iptr_r <= wrap_inc(oldest);
      icnt_r <= CW'(1);
    end
    if (cmd.inner_step) begin
      if (rdata < v_r) begin
        lt_r <= lt_r + CW'(1);
      end
      if (rdata == v_r) begin
        eq_r <= eq_r + CW'(1);
      end
      if (icnt_r != count_r) begin
        iptr_r <= wrap_inc(iptr_r);
        icnt_r <= icnt_r + CW'(1);
      end
    end
    if (cmd.outer_eval) begin
      if (lo_hit) begin
        a_r <= v_r;
      end
      if (hi_hit) begin
        b_r <= v_r;
      end
      optr_r <= wrap_inc(optr_r);
      ocnt_r <= ocnt_r + CW'(1);
    end
    if (cmd.cap_mean) begin
      avg_r <= quo[SW-1:0];
    end
    if (cmd.frac_mul) begin
      prod_r <= PROD_W'(b_r - a_r) * PROD_W'(frem_r);
    end
    if (cmd.frac_hi) begin
      fq_r <= d_q;
    end
    if (cmd.frac_rem) begin
      fz_r <= ((QW'(fh) - QW'(fq_r) * K625) << FL_W) | QW'(fy[FL_W-1:0]);
    end
    if (cmd.cap_frac) begin
      pv_r <= a_r + fq_all[SW-1:0];
    end
    if (cmd.load_out) begin
      out_r.average          <= avg_r;
      out_r.percentile_value <= pv_r;
      out_r.last_sample      <= last_r;
      out_r.sample_count     <= cnt_ext[svp_pkg::COUNT_OUT_W-1:0];
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/svp_ctrl.sv -----
// Controller state machine: handshakes and the sequence of a query.
// Depends on svp_pkg.
module svp_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [svp_pkg::OP_W-1:0]     in_op,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  svp_pkg::svp_sts_t            sts,
  output svp_pkg::svp_cmd_t            cmd
);

  svp_pkg::svp_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = (state_r == svp_pkg::ST_IDLE);
    accept        = in_valid && in_ready;

    unique case (state_r)
      svp_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            svp_pkg::OP_PUSH:  cmd.push = 1'b1;
            svp_pkg::OP_CLEAR: cmd.clear = 1'b1;
            svp_pkg::OP_QUERY: begin
              cmd.q_init = 1'b1;
              state_nxt  = svp_pkg::ST_QCHK;
            end
            default: ;
          endcase
        end
      end
      svp_pkg::ST_QCHK: begin
        if (sts.cnt_zero) begin
          state_nxt = svp_pkg::ST_DONE;
        end else begin
          cmd.rank_div = 1'b1;
          state_nxt    = svp_pkg::ST_RWAIT;
        end
      end
      svp_pkg::ST_RWAIT: begin
        cmd.cap_rank = 1'b1;
        state_nxt    = svp_pkg::ST_ORD;
      end
      svp_pkg::ST_ORD: begin
        cmd.outer_rd = 1'b1;
        state_nxt    = svp_pkg::ST_OLAT;
      end
      svp_pkg::ST_OLAT: begin
        cmd.outer_lat = 1'b1;
        state_nxt     = svp_pkg::ST_INNER;
      end
      svp_pkg::ST_INNER: begin
        cmd.inner_step = 1'b1;
        if (sts.inner_done) begin
          state_nxt = svp_pkg::ST_OEVAL;
        end
      end
      svp_pkg::ST_OEVAL: begin
        cmd.outer_eval = 1'b1;
        state_nxt      = sts.outer_last ? svp_pkg::ST_MGO : svp_pkg::ST_ORD;
      end
      svp_pkg::ST_MGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = svp_pkg::ST_MWAIT;
      end
      svp_pkg::ST_MWAIT: begin
        if (sts.div_done) begin
          cmd.cap_mean = 1'b1;
          state_nxt    = svp_pkg::ST_FMUL;
        end
      end
      svp_pkg::ST_FMUL: begin
        cmd.frac_mul = 1'b1;
        state_nxt    = svp_pkg::ST_FGO;
      end
      svp_pkg::ST_FGO: begin
        cmd.frac_hi = 1'b1;
        state_nxt   = svp_pkg::ST_FWAIT;
      end
      svp_pkg::ST_FWAIT: begin
        cmd.frac_rem = 1'b1;
        state_nxt    = svp_pkg::ST_FLO;
      end
      svp_pkg::ST_FLO: begin
        cmd.cap_frac = 1'b1;
        state_nxt    = svp_pkg::ST_DONE;
      end
      svp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = svp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = svp_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
